/* src/pba_pkg.sv */
// shared types and constants for the page bitmap allocator
// no dependencies
package pba_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned WordIdxW = 5;

  // pages covered by the free map, fixed by the 13-bit page fields of the channels
  localparam int unsigned MaxPages = 8192;

  typedef enum logic [2:0] {
    KindAllocOne  = 3'd0,
    KindAllocRun  = 3'd1,
    KindAllocDma  = 3'd2,
    KindFree      = 3'd3,
    KindFreeRun   = 3'd4,
    KindQuery     = 3'd5,
    KindSeed      = 3'd6,
    KindUnused    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoSpace  = 3'd1,
    StInvalid  = 3'd2,
    StDouble   = 3'd3,
    StBadCount = 3'd4
  } status_e;

endpackage

/* src/pba_if.sv */
// valid/ready channel interface carrying one payload struct-free field set
// uses no package
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [12:0] page_index;
  logic [13:0] page_count;
  modport source (output valid, kind, page_index, page_count, input ready);
  modport sink (input valid, kind, page_index, page_count, output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] result_page;
  logic        page_is_free;
  logic [13:0] free_page_count;
  modport source (output valid, status, result_page, page_is_free, free_page_count,
                  input ready);
  modport sink (input valid, status, result_page, page_is_free, free_page_count,
                output ready);
endinterface

/* src/page_bitmap_allocator.sv */
// page bitmap allocator top level: request decode, bit-serial map sequencer
// depends on pba_pkg and the channel interfaces in pba_if.sv
// sequencing: each page visited passes a read and a check state, each page written a take
//   or give state, and a done state registers the response; searches scan page by page
// throughput: one request at a time; no request is accepted while one is in progress or
//   while its response is still pending
// reset: async active low; map memory is cleared by a sweep over all MaxPages pages
//   after reset, during which no request is accepted
module page_bitmap_allocator #(
  parameter int unsigned DMA_LIMIT_PAGES = 4096,
  parameter int unsigned DMA_BLOCK_PAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  pba_req_if.sink     req,
  pba_rsp_if.source   rsp
);
  localparam int unsigned MaxPages = pba_pkg::MaxPages;
  localparam int unsigned AW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned PW = AW + 2;  // wide page values, holds MaxPages and sums
  localparam int unsigned DmaLim = (DMA_LIMIT_PAGES < MaxPages) ? DMA_LIMIT_PAGES
                                                               : MaxPages;

  typedef enum logic [8:0] {
    SClear  = 9'b000000001,
    SIdle   = 9'b000000010,
    SRead   = 9'b000000100,
    SCheck  = 9'b000001000,
    STake   = 9'b000010000,
    SGive   = 9'b000100000,
    SDone   = 9'b001000000,
    SOut    = 9'b010000000,
    SWait   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic mem_q [MaxPages];
  logic rd_q;
  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic          wbit;

  logic [13:0] total_q;
  logic [PW-1:0] free_tot_q, free_tot_d, hint_q, hint_d;
  logic [PW-1:0] ptr_q, ptr_d, run_q, run_d, cnt_q, cnt_d, base_q, base_d;
  logic [PW-1:0] blk_q, blk_d;
  logic [2:0]  kind_q, kind_d;
  logic [2:0]  st_q, st_d;
  logic [12:0] rpage_q, rpage_d;
  logic        qf_q, qf_d;
  logic        ov_q;
  logic [2:0]  o_st_q;
  logic [12:0] o_rp_q;
  logic        o_qf_q;
  logic [13:0] o_ft_q;
  logic        ov_d;

  logic [PW-1:0] eff_total, wtot, req_cnt;

  assign wtot = PW'(total_q);
  assign eff_total = (wtot < PW'(MaxPages)) ? wtot : PW'(MaxPages);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wbit;
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) total_q <= 14'd8192;
    else if (cfg_we_i) total_q <= cfg_wdata_i;
  end

  assign req.ready = (state_q == SIdle) && !ov_q;
  assign rsp.valid = ov_q;
  assign rsp.status = o_st_q;
  assign rsp.result_page = o_rp_q;
  assign rsp.page_is_free = o_qf_q;
  assign rsp.free_page_count = o_ft_q;

  // in-range bit of the page now under ptr
  logic cur_free;
  assign cur_free = rd_q && (ptr_q < eff_total);

  always_comb begin
    state_d = state_q;
    free_tot_d = free_tot_q;
    hint_d = hint_q;
    ptr_d = ptr_q;
    run_d = run_q;
    cnt_d = cnt_q;
    base_d = base_q;
    blk_d = blk_q;
    kind_d = kind_q;
    st_d = st_q;
    rpage_d = rpage_q;
    qf_d = qf_q;
    ov_d = ov_q && !rsp.ready;
    we = 1'b0;
    waddr = ptr_q[AW-1:0];
    wbit = 1'b0;
    raddr = ptr_q[AW-1:0];
    req_cnt = PW'(req.page_count);
    unique case (state_q)
      SClear: begin
        we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == PW'(MaxPages - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (req.valid && !ov_q) begin
          kind_d = req.kind;
          st_d = pba_pkg::StOk;
          rpage_d = '0;
          qf_d = 1'b0;
          run_d = '0;
          state_d = SDone;
          unique case (pba_pkg::kind_e'(req.kind))
            pba_pkg::KindAllocOne, pba_pkg::KindAllocRun: begin
              cnt_d = (req.kind == pba_pkg::KindAllocOne) ? PW'(1) : req_cnt;
              if (cnt_d == '0) st_d = pba_pkg::StBadCount;
              else if (hint_q == '0) st_d = pba_pkg::StNoSpace;
              else begin
                ptr_d = hint_q - 1'b1;
                state_d = SRead;
              end
            end
            pba_pkg::KindAllocDma: begin
              cnt_d = req_cnt;
              ptr_d = '0;
              blk_d = '0;
              if (req_cnt == '0) st_d = pba_pkg::StBadCount;
              else if (req_cnt > PW'(DMA_BLOCK_PAGES) || DmaLim == 0)
                st_d = pba_pkg::StNoSpace;
              else state_d = SRead;
            end
            pba_pkg::KindFree, pba_pkg::KindFreeRun: begin
              cnt_d = (req.kind == pba_pkg::KindFree) ? PW'(1) : req_cnt;
              ptr_d = PW'(req.page_index);
              base_d = PW'(req.page_index);
              if (cnt_d == '0) st_d = pba_pkg::StBadCount;
              else if (PW'(req.page_index) + cnt_d > eff_total) st_d = pba_pkg::StInvalid;
              else state_d = SRead;
            end
            pba_pkg::KindQuery, pba_pkg::KindSeed: begin
              ptr_d = PW'(req.page_index);
              cnt_d = PW'(1);
              base_d = PW'(req.page_index);
              if (PW'(req.page_index) >= eff_total) st_d = pba_pkg::StInvalid;
              else state_d = SRead;
            end
            default: st_d = pba_pkg::StInvalid;
          endcase
        end
      end
      SRead: state_d = SCheck;  // memory read in flight
      SCheck: begin
        state_d = SRead;
        unique case (pba_pkg::kind_e'(kind_q))
          pba_pkg::KindAllocOne, pba_pkg::KindAllocRun: begin
            if (cur_free) begin
              run_d = run_q + 1'b1;
              if (run_q + 1'b1 >= cnt_q) begin
                rpage_d = ptr_q[12:0];
                base_d = ptr_q + cnt_q;
                state_d = STake;
              end else if (ptr_q == '0) begin
                st_d = pba_pkg::StNoSpace;
                state_d = SDone;
              end else ptr_d = ptr_q - 1'b1;
            end else begin
              run_d = '0;
              if (ptr_q == '0) begin
                st_d = pba_pkg::StNoSpace;
                state_d = SDone;
              end else ptr_d = ptr_q - 1'b1;
            end
          end
          pba_pkg::KindAllocDma: begin
            logic [PW-1:0] r;
            // blk tracks the position of ptr inside its dma block
            r = cur_free ? ((blk_q == '0) ? PW'(1) : run_q + 1'b1) : '0;
            run_d = r;
            if (cur_free && r >= cnt_q) begin
              ptr_d = ptr_q + 1'b1 - cnt_q;
              rpage_d = 13'(ptr_q + 1'b1 - cnt_q);
              base_d = ptr_q + 1'b1;
              state_d = STake;
            end else if (ptr_q == PW'(DmaLim - 1)) begin
              st_d = pba_pkg::StNoSpace;
              state_d = SDone;
            end else begin
              ptr_d = ptr_q + 1'b1;
              blk_d = (blk_q == PW'(DMA_BLOCK_PAGES - 1)) ? '0 : blk_q + 1'b1;
            end
          end
          pba_pkg::KindFree, pba_pkg::KindFreeRun: begin
            if (rd_q) begin
              st_d = pba_pkg::StDouble;
              state_d = SDone;
            end else if (ptr_q + 1'b1 == base_q + cnt_q) begin
              ptr_d = base_q;
              state_d = SGive;
            end else ptr_d = ptr_q + 1'b1;
          end
          pba_pkg::KindQuery: begin
            qf_d = rd_q;
            state_d = SDone;
          end
          pba_pkg::KindSeed: begin
            state_d = rd_q ? SDone : SGive;
          end
          default: state_d = SDone;
        endcase
      end
      STake: begin
        // clear pages ptr .. base-1 for alloc (ptr walks up)
        we = 1'b1;
        if (free_tot_q != '0) free_tot_d = free_tot_q - 1'b1;
        if (hint_q == ptr_q + 1'b1) hint_d = ptr_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q + 1'b1 == base_q) state_d = SDone;
      end
      SGive: begin
        we = 1'b1;
        wbit = 1'b1;
        free_tot_d = free_tot_q + 1'b1;
        if (ptr_q + 1'b1 > hint_q) hint_d = ptr_q + 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q + 1'b1 == base_q + cnt_q) state_d = SDone;
      end
      SDone: begin
        ov_d = 1'b1;
        state_d = SWait;
      end
      SWait, SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      free_tot_q <= '0;
      hint_q <= '0;
      ptr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_tot_q <= free_tot_d;
      hint_q <= hint_d;
      ptr_q <= ptr_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
    cnt_q <= cnt_d;
    base_q <= base_d;
    blk_q <= blk_d;
    kind_q <= kind_d;
    st_q <= st_d;
    rpage_q <= rpage_d;
    qf_q <= qf_d;
    if (state_q == SDone) begin
      o_st_q <= st_q;
      o_rp_q <= rpage_q;
      o_qf_q <= qf_q;
      o_ft_q <= free_tot_q[13:0];
    end
  end
endmodule

/* src/pba_checker.sv */
// port-level checker for the page bitmap allocator, bound to the top level
// depends on pba_pkg for status codes
module pba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic        rsp_free,
  input logic [12:0] rsp_page
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("response dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("request accepted while a response is pending");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_status <= pba_pkg::StBadCount)
    else $error("status code out of range");
  a_free_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_free |-> rsp_status == pba_pkg::StOk)
    else $error("free answer on a failed request");
  a_page_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_page != 13'd0 |-> rsp_status == pba_pkg::StOk)
    else $error("result page on a failed request");
endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_free(rsp.page_is_free), .rsp_page(rsp.result_page)
);

/* dv/tb_top.sv */
// testbench for page_bitmap_allocator: directed and random requests, in-order response check
// depends on pba_pkg, pba_if.sv and the allocator rtl
module tb_top;

  localparam int unsigned NumPages = 8192;
  localparam int unsigned DmaLimit = 4096;
  localparam int unsigned DmaBlock = 16;

  typedef struct packed {
    pba_pkg::status_e status;
    logic [12:0]      page;
    logic             is_free;
    logic [13:0]      free_cnt;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [13:0] cfg_wdata_i = '0;

  pba_req_if req_ch ();
  pba_rsp_if rsp_ch ();

  page_bitmap_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the allocator state
  bit          page_bit [NumPages];
  int unsigned pages_free;
  int unsigned hint_top;
  int unsigned page_limit;

  alloc_rsp_t  pending_rsp [$];
  int unsigned errors;
  bit          calm_mode;
  int unsigned hold_cycles;

  function automatic int unsigned usable_pages();
    return (page_limit < NumPages) ? page_limit : NumPages;
  endfunction

  function automatic bit is_usable(int unsigned p);
    return (p < usable_pages()) && page_bit[p];
  endfunction

  function automatic void take_one(int unsigned p);
    page_bit[p] = 1'b0;
    if (pages_free != 0) pages_free--;
    if (hint_top == p + 1) hint_top = p;
  endfunction

  function automatic void give_one(int unsigned p);
    page_bit[p] = 1'b1;
    pages_free++;
    if (p + 1 > hint_top) hint_top = p + 1;
  endfunction

  function automatic alloc_rsp_t serve_request(pba_pkg::kind_e kind, int unsigned idx,
                                               int unsigned cnt);
    alloc_rsp_t  r;
    int unsigned run;
    bit          found;
    int unsigned p;
    r = '0;
    r.status = pba_pkg::StOk;
    run = 0;
    found = 0;
    case (kind)
      pba_pkg::KindAllocOne, pba_pkg::KindAllocRun: begin
        if (kind == pba_pkg::KindAllocOne) cnt = 1;
        if (cnt == 0) begin
          r.status = pba_pkg::StBadCount;
        end else begin
          for (int unsigned i = hint_top; i != 0 && !found; i--) begin
            p = i - 1;
            if (is_usable(p)) begin
              run++;
              if (run >= cnt) begin
                for (int unsigned q = p; q < p + cnt; q++) take_one(q);
                r.page = p[12:0];
                found = 1;
              end
            end else begin
              run = 0;
            end
          end
          if (!found) r.status = pba_pkg::StNoSpace;
        end
      end
      pba_pkg::KindAllocDma: begin
        if (cnt == 0) begin
          r.status = pba_pkg::StBadCount;
        end else begin
          for (int unsigned i = 0; i < DmaLimit && !found; i++) begin
            if (i % DmaBlock == 0) run = 0;
            if (is_usable(i)) begin
              run++;
              if (run >= cnt) begin
                for (int unsigned q = i + 1 - cnt; q <= i; q++) take_one(q);
                p = i + 1 - cnt;
                r.page = p[12:0];
                found = 1;
              end
            end else begin
              run = 0;
            end
          end
          if (!found) r.status = pba_pkg::StNoSpace;
        end
      end
      pba_pkg::KindFree, pba_pkg::KindFreeRun: begin
        if (kind == pba_pkg::KindFree) cnt = 1;
        if (cnt == 0) begin
          r.status = pba_pkg::StBadCount;
        end else if (idx + cnt > usable_pages()) begin
          r.status = pba_pkg::StInvalid;
        end else begin
          for (int unsigned q = idx; q < idx + cnt; q++)
            if (page_bit[q]) r.status = pba_pkg::StDouble;
          if (r.status == pba_pkg::StOk)
            for (int unsigned q = idx; q < idx + cnt; q++) give_one(q);
        end
      end
      pba_pkg::KindQuery: begin
        if (idx >= usable_pages()) r.status = pba_pkg::StInvalid;
        else r.is_free = page_bit[idx];
      end
      pba_pkg::KindSeed: begin
        if (idx >= usable_pages()) r.status = pba_pkg::StInvalid;
        else if (!page_bit[idx]) give_one(idx);
      end
      default: r.status = pba_pkg::StInvalid;
    endcase
    r.free_cnt = pages_free[13:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(15, 0);
    if (calm_mode || r < 8) return 0;
    if (r < 14) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_req(pba_pkg::kind_e kind, int unsigned idx, int unsigned cnt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.page_index <= idx[12:0];
    req_ch.page_count <= cnt[13:0];
    do @(posedge clk_i); while (!req_ch.ready);
    pending_rsp.push_back(serve_request(kind, idx, cnt));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_total(int unsigned value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[13:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    page_limit = value;
    @(posedge clk_i);
  endtask

  // receiver: random stalls, quiet stretches, and long hold-offs on request
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!calm_mode && $urandom_range(3, 0) == 0)
          stall = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      end
    end
  end

  // response check, oldest expectation first
  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected transaction status %0d", $time, rsp_ch.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.result_page !== want.page) begin
          $display("%0t result_page exp %0d got %0d", $time, want.page, rsp_ch.result_page);
          errors++;
        end
        if (rsp_ch.page_is_free !== want.is_free) begin
          $display("%0t page_is_free exp %0d got %0d", $time, want.is_free,
                   rsp_ch.page_is_free);
          errors++;
        end
        if (rsp_ch.free_page_count !== want.free_cnt) begin
          $display("%0t free_page_count exp %0d got %0d", $time, want.free_cnt,
                   rsp_ch.free_page_count);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    write_total(NumPages);
    send_req(pba_pkg::KindQuery, 0, 0);
    send_req(pba_pkg::KindAllocOne, 0, 0);        // nothing free yet
    send_req(pba_pkg::KindFree, 0, 0);
    send_req(pba_pkg::KindFree, 0, 0);            // double free
    send_req(pba_pkg::KindSeed, 0, 0);            // seed of a free page
    send_req(pba_pkg::KindQuery, 0, 0);
    send_req(pba_pkg::KindAllocOne, 0, 0);
    send_req(pba_pkg::KindFreeRun, 4, 8);
    send_req(pba_pkg::KindFreeRun, 8, 5);         // run overlaps free pages
    send_req(pba_pkg::KindAllocRun, 0, 4);
    send_req(pba_pkg::KindAllocDma, 0, 17);       // longer than a dma block
    send_req(pba_pkg::KindAllocDma, 0, 4);
    send_req(pba_pkg::KindFreeRun, 14, 4);
    send_req(pba_pkg::KindAllocDma, 0, 4);        // would straddle a block boundary
    send_req(pba_pkg::KindAllocDma, 0, 2);
    send_req(pba_pkg::KindUnused, 5, 5);
    send_req(pba_pkg::KindAllocRun, 0, 0);
    send_req(pba_pkg::KindAllocDma, 0, 0);
    send_req(pba_pkg::KindFreeRun, 3, 0);
    send_req(pba_pkg::KindAllocRun, 0, 100);      // longer than anything free
    send_req(pba_pkg::KindFreeRun, 8000, 8192);   // runs past the end
  endtask

  task automatic test_random(int unsigned total, int unsigned count);
    int unsigned r;
    int unsigned lim;
    write_total(total);
    lim = (total == 0) ? 1 : total;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) calm_mode = ($urandom_range(3, 0) == 0);
      r = $urandom_range(99, 0);
      if (r < 20)
        send_req(pba_pkg::KindSeed, $urandom_range(lim - 1, 0), $urandom_range(16383, 0));
      else if (r < 34) send_req(pba_pkg::KindFree, $urandom_range(lim - 1, 0), 0);
      else if (r < 44)
        send_req(pba_pkg::KindFreeRun, $urandom_range(lim - 1, 0), $urandom_range(8, 1));
      else if (r < 64) send_req(pba_pkg::KindAllocOne, $urandom_range(8191, 0), 0);
      else if (r < 73) send_req(pba_pkg::KindAllocRun, 0, $urandom_range(8, 1));
      else if (r < 76)
        send_req(pba_pkg::KindAllocDma, 0,
                 ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1));
      else if (r < 88) send_req(pba_pkg::KindQuery, $urandom_range(lim - 1, 0), 0);
      else if (r < 91) send_req(pba_pkg::kind_e'($urandom_range(4, 1)), 0, 0);
      else send_req(pba_pkg::kind_e'($urandom_range(7, 3)), $urandom_range(8191, 0),
                    $urandom_range(16383, 0));
    end
    calm_mode = 0;
  endtask

  task automatic test_backpressure();
    write_total(128);
    hold_cycles = 400;
    for (int unsigned n = 0; n < 24; n++)
      send_req(($urandom_range(1, 0) != 0) ? pba_pkg::KindSeed : pba_pkg::KindQuery,
               $urandom_range(127, 0), 0);
  endtask

  task automatic test_zero_total();
    write_total(0);
    send_req(pba_pkg::KindQuery, 0, 0);
    send_req(pba_pkg::KindSeed, 0, 0);
    send_req(pba_pkg::KindFree, 0, 0);
    send_req(pba_pkg::KindAllocOne, 0, 0);
    send_req(pba_pkg::KindAllocDma, 0, 1);
  endtask

  // last, since a high hint makes every later downward search long
  task automatic test_full_range();
    write_total(NumPages);
    send_req(pba_pkg::KindQuery, 8191, 0);
    send_req(pba_pkg::KindSeed, 8191, 0);
    send_req(pba_pkg::KindQuery, 8191, 0);
    send_req(pba_pkg::KindAllocOne, 0, 0);
    send_req(pba_pkg::KindFree, 8191, 0);
    send_req(pba_pkg::KindFreeRun, 8184, 8);
    send_req(pba_pkg::KindFreeRun, 0, 8192);
    send_req(pba_pkg::KindAllocRun, 0, 8192);
    write_total(8000);
    send_req(pba_pkg::KindQuery, 8100, 0);
    send_req(pba_pkg::KindFreeRun, 7990, 20);
  endtask

  initial begin
    errors = 0;
    calm_mode = 0;
    hold_cycles = 0;
    page_limit = NumPages;
    pages_free = 0;
    hint_top = 0;
    req_ch.valid = 1'b0;
    req_ch.kind = pba_pkg::KindQuery;
    req_ch.page_index = '0;
    req_ch.page_count = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(96, 600);
    test_backpressure();
    test_random(300, 650);
    test_zero_total();
    test_random(700, 600);
    test_full_range();
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
src/pba_pkg.sv
src/pba_if.sv
src/page_bitmap_allocator.sv
src/pba_checker.sv
dv/tb_top.sv
